### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define LPHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LPHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/lphs_pkg.sv
package lphs_pkg;

  // Table geometry
  localparam int TABLE_SLOTS   = 26;
  localparam int MAX_KEY_CHARS = 8;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);

  // Beat fields
  localparam int KEY_W      = 64;
  localparam int KEY_CHARS  = KEY_W / 8;
  localparam int LEN_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7a;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_DEL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SLOT_NEVER = 2'd0,
    SLOT_OCC   = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED    = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_DELETED  = 3'd2,
    RES_NOTFOUND = 3'd3,
    RES_FULL     = 3'd4,
    RES_BAD      = 3'd5
  } res_status_t;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_PROBE,
    PS_DONE
  } probe_state_t;

  // Normalized request from the input side
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             bad;
    logic [KEY_W-1:0] key;
    slot_idx_t        home;
  } probe_req_t;

  // Key store write port
  typedef struct packed {
    logic      en;
    slot_idx_t addr;
  } ram_wr_t;

  // Finished result toward the output register
  typedef struct packed {
    logic        valid;
    res_status_t status;
    slot_idx_t   slot;
  } probe_res_t;

endpackage

### hdl/lphs_key_ram.sv
// Key store: one write port, one read port with registered data.
module lphs_key_ram (
  input  logic                      clk,
  input  lphs_pkg::ram_wr_t         wr,
  input  logic [lphs_pkg::KEY_W-1:0] wr_data,
  input  lphs_pkg::slot_idx_t       rd_addr,
  output logic [lphs_pkg::KEY_W-1:0] rd_data
);

  logic [lphs_pkg::KEY_W-1:0] mem [lphs_pkg::TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/lphs_probe.sv
// Probe sequencer: walks the table one slot per cycle from home, comparing
// the stored key and tracking the first reusable slot on the same lap.
module lphs_probe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lphs_pkg::probe_req_t        req,
  output logic                        req_ready,
  output lphs_pkg::probe_res_t        res,
  input  logic                        res_ready,
  output lphs_pkg::ram_wr_t           ram_wr,
  output logic [lphs_pkg::KEY_W-1:0]  ram_wr_data,
  output lphs_pkg::slot_idx_t         ram_rd_addr,
  input  logic [lphs_pkg::KEY_W-1:0]  ram_rd_data
);

  localparam lphs_pkg::slot_idx_t LAST_SLOT =
    lphs_pkg::SLOT_W'(lphs_pkg::TABLE_SLOTS - 1);

  lphs_pkg::probe_state_t state_r, state_nxt;

  lphs_pkg::slot_idx_t        slot_r, slot_nxt;
  lphs_pkg::slot_idx_t        cnt_r, cnt_nxt;
  logic                       free_found_r, free_found_nxt;
  lphs_pkg::slot_idx_t        free_slot_r, free_slot_nxt;
  lphs_pkg::op_t              op_r, op_nxt;
  logic [lphs_pkg::KEY_W-1:0] key_r, key_nxt;
  lphs_pkg::slot_idx_t        home_r, home_nxt;
  lphs_pkg::res_status_t      res_status_r, res_status_nxt;
  lphs_pkg::slot_idx_t        res_slot_r, res_slot_nxt;

  lphs_pkg::slot_state_t slot_st_r [lphs_pkg::TABLE_SLOTS];

  lphs_pkg::slot_state_t cur_st;
  logic                  occ, never, hit, last_probe, probe_end, have_free;
  lphs_pkg::slot_idx_t   free_now;
  logic                  st_wr_en;
  lphs_pkg::slot_idx_t   st_wr_addr;
  lphs_pkg::slot_state_t st_wr_val;

  // Slot decode for the current probe
  always_comb begin
    cur_st     = slot_st_r[slot_r];
    occ        = (cur_st == lphs_pkg::SLOT_OCC);
    never      = (cur_st == lphs_pkg::SLOT_NEVER);
    hit        = occ && (ram_rd_data == key_r);
    last_probe = (cnt_r == LAST_SLOT);
    probe_end  = hit || never || last_probe;
    have_free  = free_found_r || !occ;
    free_now   = free_found_r ? free_slot_r : slot_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lphs_pkg::PS_IDLE: begin
        if (req.valid) begin
          state_nxt = req.bad ? lphs_pkg::PS_DONE : lphs_pkg::PS_PROBE;
        end
      end
      lphs_pkg::PS_PROBE: begin
        if (probe_end) begin
          state_nxt = lphs_pkg::PS_DONE;
        end
      end
      lphs_pkg::PS_DONE: begin
        if (res_ready) begin
          state_nxt = lphs_pkg::PS_IDLE;
        end
      end
      default: state_nxt = lphs_pkg::PS_IDLE;
    endcase
  end

  // Outputs and table writes
  always_comb begin
    req_ready   = (state_r == lphs_pkg::PS_IDLE);
    res.valid   = (state_r == lphs_pkg::PS_DONE);
    res.status  = res_status_r;
    res.slot    = res_slot_r;
    ram_wr.en   = (state_r == lphs_pkg::PS_PROBE) && probe_end && !hit &&
                  (op_r == lphs_pkg::OP_ADD) && have_free;
    ram_wr.addr = free_now;
    ram_wr_data = key_r;
    ram_rd_addr = slot_nxt;
    st_wr_en    = 1'b0;
    st_wr_addr  = free_now;
    st_wr_val   = lphs_pkg::SLOT_OCC;
    case (state_r)
      lphs_pkg::PS_PROBE: begin
        if (hit && (op_r == lphs_pkg::OP_DEL)) begin
          st_wr_en   = 1'b1;
          st_wr_addr = slot_r;
          st_wr_val  = lphs_pkg::SLOT_TOMB;
        end else if (ram_wr.en) begin
          st_wr_en = 1'b1;
        end
      end
      default: st_wr_en = 1'b0;
    endcase
  end

  // Probe datapath
  always_comb begin
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    case (state_r)
      lphs_pkg::PS_IDLE: begin
        slot_nxt       = req.home;
        cnt_nxt        = '0;
        free_found_nxt = 1'b0;
        op_nxt         = req.op;
        key_nxt        = req.key;
        home_nxt       = req.home;
        res_status_nxt = lphs_pkg::RES_BAD;
        res_slot_nxt   = '0;
      end
      lphs_pkg::PS_PROBE: begin
        if (!free_found_r && !occ) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = slot_r;
        end
        if (!probe_end) begin
          slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (hit) begin
          res_slot_nxt   = slot_r;
          res_status_nxt = (op_r == lphs_pkg::OP_ADD) ? lphs_pkg::RES_PRESENT
                                                      : lphs_pkg::RES_DELETED;
        end else if (op_r == lphs_pkg::OP_DEL) begin
          res_slot_nxt   = home_r;
          res_status_nxt = lphs_pkg::RES_NOTFOUND;
        end else if (have_free) begin
          res_slot_nxt   = free_now;
          res_status_nxt = lphs_pkg::RES_ADDED;
        end else begin
          res_slot_nxt   = home_r;
          res_status_nxt = lphs_pkg::RES_FULL;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphs_pkg::PS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Slot status flags: cleared to never used at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
        slot_st_r[i] <= lphs_pkg::SLOT_NEVER;
      end
    end else if (st_wr_en) begin
      slot_st_r[st_wr_addr] <= st_wr_val;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    cnt_r        <= cnt_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

endmodule

### hdl/linear_probe_hash_set.sv
// Channel  Dir  tdata                              tuser
// in_      in   [63:0] key, [67:64] key_len        [0] op (0 add, 1 delete)
// out_     out  [2:0] status, [7:3] slot           -
//
// An item takes P = 1..26 probes; a bad key skips probing. One slot is
// checked per cycle, set by the single key compare fed from the key store
// read port.
// Reset (rst_n low, synchronous) marks every slot never used and drops out_tvalid.
// A result waiting in the output register does not stop the next item from being
// accepted; the following result holds in the sequencer until the register frees.
module linear_probe_hash_set (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lphs_pkg::IN_DATA_W-1:0]    in_tdata,   // key[63:0], key_len[67:64]
  input  logic                              in_tuser,   // op[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lphs_pkg::OUT_DATA_W-1:0]   out_tdata   // status[2:0], slot[7:3]
);

  logic [lphs_pkg::KEY_W-1:0] key_in, key_norm, ram_wr_data, ram_rd_data;
  logic [lphs_pkg::LEN_W-1:0] key_len;
  logic [7:0]                 last_ch;
  lphs_pkg::probe_req_t       req;
  lphs_pkg::probe_res_t       res;
  lphs_pkg::ram_wr_t          ram_wr;
  lphs_pkg::slot_idx_t        ram_rd_addr;
  logic                       res_ready;

  logic                                out_valid_r, out_valid_nxt;
  logic [lphs_pkg::OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  assign key_in  = in_tdata[lphs_pkg::KEY_W-1:0];
  assign key_len = in_tdata[lphs_pkg::KEY_W +: lphs_pkg::LEN_W];

  // Key normalization: keep the low key_len bytes, pick the last character
  always_comb begin
    key_norm = '0;
    last_ch  = '0;
    for (int i = 0; i < lphs_pkg::KEY_CHARS; i++) begin
      if (lphs_pkg::LEN_W'(i) < key_len) begin
        key_norm[8*i +: 8] = key_in[8*i +: 8];
      end
      if (key_len == lphs_pkg::LEN_W'(i + 1)) begin
        last_ch = key_in[8*i +: 8];
      end
    end
  end

  always_comb begin
    req.valid = in_tvalid;
    req.op    = lphs_pkg::op_t'(in_tuser);
    req.key   = key_norm;
    req.bad   = (key_len == '0) ||
                (key_len > lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_CHARS)) ||
                (last_ch < lphs_pkg::CHAR_A) || (last_ch > lphs_pkg::CHAR_Z);
    req.home  = lphs_pkg::SLOT_W'(last_ch - lphs_pkg::CHAR_A);
  end

  lphs_probe u_probe (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .req_ready   (in_tready),
    .res         (res),
    .res_ready   (res_ready),
    .ram_wr      (ram_wr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  lphs_key_ram u_key_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
      if (res.valid) begin
        out_data_nxt = {lphs_pkg::OUT_SLOT_W'(res.slot), res.status};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/lphs_checker.sv
`include "assert_macros.svh"

// Port-level checks on the hash set.
module lphs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lphs_pkg::OUT_DATA_W-1:0] out_tdata
);

  `LPHS_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "out_tvalid set after reset")
  `LPHS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `LPHS_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "beat accepted while probing")
  `LPHS_ASSERT(a_status_range, out_tvalid |-> out_tdata[2:0] <= lphs_pkg::RES_BAD, "status code out of range")
  `LPHS_ASSERT(a_bad_slot_zero, out_tvalid && (out_tdata[2:0] == lphs_pkg::RES_BAD) |-> out_tdata[7:3] == '0, "bad key with nonzero slot")

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);
